// ----- sv/nseq_pkg.sv -----
// Shared types, constants and codes for the eight-step note sequencer.
// No dependencies; imported by every module of the block except nseq_ram.
package nseq_pkg;

	// Fixed field widths of the request and event words
	localparam int CMD_W  = 1;
	localparam int POS_W  = 8;
	localparam int IDX_W  = 3;
	localparam int MASK_W = 12;
	localparam int NOTE_W = 7;
	localparam int VEL_W  = 7;

	// Defaults for the top-level parameters
	localparam int STEP_COUNT_DEF = 8;
	localparam int NOTE_COUNT_DEF = 12;

	// Note and velocity values
	localparam logic [NOTE_W-1:0] NOTE_BASE = NOTE_W'(48);
	localparam logic [VEL_W-1:0]  VEL_ON    = VEL_W'(127);
	localparam logic [VEL_W-1:0]  VEL_OFF   = VEL_W'(0);

	// Note-off position after reset
	localparam logic [POS_W-1:0] OFF_POS_RST = POS_W'(24);

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TICK  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [POS_W-1:0]  tick_position;
		logic [IDX_W-1:0]  step_index;
		logic [MASK_W-1:0] step_mask;
	} req_word_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note_number;
		logic [VEL_W-1:0]  velocity;
		logic              last_of_run;
	} evt_word_t;

	// Controller -> datapath
	typedef struct packed {
		logic do_write;   // store request mask into the step table
		logic do_fetch;   // read step at pointer, advance pointer
		logic do_load;    // take fetched mask as held and run mask (note-on)
		logic do_off;     // take held mask as run mask (note-off)
		logic do_emit;    // load next event into the output register
	} nseq_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic is_write;    // request is a step write
		logic pos_zero;    // tick at position zero
		logic pos_match;   // tick at the note-off position
		logic held_empty;  // held mask has no notes
		logic fetch_empty; // fetched mask has no notes
		logic run_last;    // one note left in the run mask
		logic out_free;    // output register can take an event
	} nseq_sts_t;

endpackage

// ----- sv/nseq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nseq_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/nseq_ctrl.sv -----
// Controller state machine of the note sequencer.
// Depends on nseq_pkg for the command and status structs.
module nseq_ctrl
	import nseq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  nseq_sts_t sts,
	output nseq_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FETCH = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (sts.is_write) begin
						cmd.do_write = 1'b1;
					end else if (sts.pos_zero) begin
						cmd.do_fetch = 1'b1;
						state_d      = ST_FETCH;
					end else if (sts.pos_match) begin
						cmd.do_off = 1'b1;
						if (!sts.held_empty) begin
							state_d = ST_EMIT;
						end
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FETCH: begin
				cmd.do_load = 1'b1;
				state_d     = sts.fetch_empty ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.do_emit = 1'b1;
					if (sts.run_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/nseq_dp.sv -----
// Datapath: step table, pointer, held and run masks, output register.
// Depends on nseq_pkg and nseq_ram.
module nseq_dp
	import nseq_pkg::*;
#(
	parameter int STEP_COUNT = STEP_COUNT_DEF,
	parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  req_word_t        req_word,
	output logic             evt_valid,
	input  logic             evt_stall,
	output evt_word_t        evt_word,
	input  logic             cfg_we,
	input  logic [POS_W-1:0] cfg_wdata,
	input  nseq_cmd_t        cmd,
	output nseq_sts_t        sts
);

	localparam int PTR_W  = $clog2(STEP_COUNT);
	localparam int AW     = (IDX_W > PTR_W) ? IDX_W : PTR_W;
	localparam int MW     = (MASK_W > NOTE_COUNT) ? MASK_W : NOTE_COUNT;
	localparam int NIDX_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

	logic [POS_W-1:0]      off_pos_q;
	logic [PTR_W-1:0]      ptr_q;
	logic [STEP_COUNT-1:0] valid_q;
	logic                  rd_valid_q;
	logic [NOTE_COUNT-1:0] held_q;
	logic [NOTE_COUNT-1:0] run_q;
	logic                  vel_on_q;
	logic                  evt_valid_q;
	evt_word_t             evt_word_q;

	logic [AW-1:0]         idx_ext;
	logic                  idx_in_range;
	logic [MW-1:0]         mask_ext;
	logic [NOTE_COUNT-1:0] wr_mask;
	logic [NOTE_COUNT-1:0] ram_rdata;
	logic [NOTE_COUNT-1:0] fetched;
	logic [NOTE_COUNT-1:0] run_rest;
	logic [NIDX_W-1:0]     lo_idx;
	logic                  wr_en;

	assign idx_ext      = AW'(req_word.step_index);
	// one extra bit so a power-of-two step count does not fold to zero
	assign idx_in_range = ({1'b0, idx_ext} < (AW+1)'(STEP_COUNT));
	assign mask_ext     = MW'(req_word.step_mask);
	assign wr_mask      = mask_ext[NOTE_COUNT-1:0];
	assign wr_en        = cmd.do_write && idx_in_range;

	nseq_ram #(
		.WIDTH(NOTE_COUNT),
		.DEPTH(STEP_COUNT)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(idx_ext[PTR_W-1:0]),
		.wdata(wr_mask),
		.re   (cmd.do_fetch),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	// never-written steps read as empty
	assign fetched  = rd_valid_q ? ram_rdata : '0;
	assign run_rest = run_q & (run_q - NOTE_COUNT'(1));

	always_comb begin
		lo_idx = '0;
		for (int k = NOTE_COUNT - 1; k >= 0; k--) begin
			if (run_q[k]) begin
				lo_idx = NIDX_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_pos_q   <= OFF_POS_RST;
			ptr_q       <= '0;
			valid_q     <= '0;
			rd_valid_q  <= 1'b0;
			held_q      <= '0;
			run_q       <= '0;
			vel_on_q    <= 1'b0;
			evt_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				off_pos_q <= cfg_wdata;
			end
			if (wr_en) begin
				valid_q[idx_ext[PTR_W-1:0]] <= 1'b1;
			end
			if (cmd.do_fetch) begin
				rd_valid_q <= valid_q[ptr_q];
				ptr_q      <= (ptr_q == PTR_W'(STEP_COUNT - 1)) ? '0 : ptr_q + PTR_W'(1);
				vel_on_q   <= 1'b1;
			end
			if (cmd.do_load) begin
				held_q <= fetched;
				run_q  <= fetched;
			end
			if (cmd.do_off) begin
				run_q    <= held_q;
				vel_on_q <= 1'b0;
			end
			if (cmd.do_emit) begin
				run_q <= run_rest;
			end
			if (cmd.do_emit) begin
				evt_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_emit) begin
			evt_word_q.note_number <= NOTE_BASE + NOTE_W'(1) + NOTE_W'(lo_idx);
			evt_word_q.velocity    <= vel_on_q ? VEL_ON : VEL_OFF;
			evt_word_q.last_of_run <= (run_rest == '0);
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt_word  = evt_word_q;

	assign sts.is_write    = (req_word.command == CMD_WRITE);
	assign sts.pos_zero    = (req_word.tick_position == '0);
	assign sts.pos_match   = (req_word.tick_position == off_pos_q);
	assign sts.held_empty  = (held_q == '0);
	assign sts.fetch_empty = (fetched == '0);
	assign sts.run_last    = (run_rest == '0);
	assign sts.out_free    = !evt_valid_q || !evt_stall;

endmodule

// ----- sv/eight_step_note_sequencer_top.sv -----
// Top level of the eight-step note sequencer.
// Depends on nseq_pkg, nseq_ctrl, nseq_dp (which holds nseq_ram).
//
//  channel | valid     | stall     | word      | direction
//  --------+-----------+-----------+-----------+----------
//  request | req_valid | req_stall | req_word  | in
//  event   | evt_valid | evt_stall | evt_word  | out
//  config  | cfg_we    | (none)    | cfg_wdata | in
//
// A step write is taken without leaving idle. A tick at position zero runs
// accept, step-table read, then one event per cycle for N set notes; a
// note-off tick runs accept, then its events. The table read is registered,
// the output register holds one event; event stalls hold the run in place.
// Reset clears pointer, held mask, table valid bits and the note-off
// position (back to 24); the table data itself is not swept.
module eight_step_note_sequencer_top
	import nseq_pkg::*;
#(
	parameter int STEP_COUNT = STEP_COUNT_DEF,
	parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_word_t        req_word,
	output logic             evt_valid,
	input  logic             evt_stall,
	output evt_word_t        evt_word,
	input  logic             cfg_we,
	input  logic [POS_W-1:0] cfg_wdata
);

	nseq_cmd_t cmd;
	nseq_sts_t sts;

	// Sequencing: idle / table read / event run
	nseq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage and event generation
	nseq_dp #(
		.STEP_COUNT(STEP_COUNT),
		.NOTE_COUNT(NOTE_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_word (req_word),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt_word (evt_word),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ----- sv/nseq_checker.sv -----
// Port-level checks for the note sequencer, bound to the top level.
// Depends on nseq_pkg and eight_step_note_sequencer_top.
module nseq_checker
	import nseq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_word_t req_word,
	input logic      evt_valid,
	input logic      evt_stall,
	input evt_word_t evt_word
);

	// a step write never leaves the block busy
	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_word.command == CMD_WRITE |=> !req_stall)
		else $error("busy after step write");

	// a tick at position zero always goes through a table read
	a_fetch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_word.command == CMD_TICK
		&& req_word.tick_position == '0 |=> req_stall)
		else $error("no table read after position-zero tick");

	// while a run is unfinished no new word is taken
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_word.last_of_run |-> req_stall)
		else $error("request taken in the middle of a run");

	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_stall |=> evt_valid && $stable(evt_word))
		else $error("stalled event changed");

endmodule

bind eight_step_note_sequencer_top nseq_checker u_nseq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req_word (req_word),
	.evt_valid(evt_valid),
	.evt_stall(evt_stall),
	.evt_word (evt_word)
);

// ----- dv/tb_eight_step_note_sequencer_top.sv -----
// Self-checking testbench for eight_step_note_sequencer_top: step writes, ticks,
// note-on and note-off runs, note-off position changes, and output back-pressure.
// Depends on nseq_pkg and the sequencer RTL only.
module tb_eight_step_note_sequencer_top;
	import nseq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// run limits and pacing
	localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run
	localparam int DRAIN_PAD   = 16;      // settle time for a trailing empty tick
	localparam int HOLD_CYCLES = 200;     // long receiver hold-off
	localparam int IDLE_PCT    = 33;
	localparam int RANDOM_WORDS = 60;
	localparam int MAX_SHOWN   = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req_word = '0;
	logic      evt_valid;
	logic      evt_stall = 1'b0;
	evt_word_t evt_word;
	logic      cfg_we = 1'b0;
	logic [POS_W-1:0] cfg_wdata = '0;

	// predictor state: step table, play pointer, held mask, note-off position
	logic [MASK_W-1:0] step_masks [STEP_COUNT_DEF];
	logic [IDX_W-1:0]  play_ptr;
	logic [MASK_W-1:0] held_notes;
	logic [POS_W-1:0]  note_off_pos;

	// note events still owed by the block, oldest first
	evt_word_t expected_notes [$];

	int  error_count = 0;
	int  cycle_count = 0;
	bit  quiet_stretch = 1'b0;  // no idling on either side while set
	int  hold_ask = 0;          // bumped by a test to request a long hold-off
	int  hold_seen = 0;
	int  hold_left = 0;

	eight_step_note_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt_word  (evt_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding", cycle_count,
				expected_notes.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= MAX_SHOWN)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// Append one run of events for a mask: lowest note first, last flag on the top note.
	function automatic void queue_run(input logic [MASK_W-1:0] mask,
			input logic [VEL_W-1:0] vel);
		evt_word_t ev;
		int top;
		top = -1;
		for (int k = 0; k < NOTE_COUNT_DEF; k++)
			if (mask[k]) top = k;
		for (int k = 0; k < NOTE_COUNT_DEF; k++) begin
			if (mask[k]) begin
				ev.note_number = NOTE_BASE + NOTE_W'(k + 1);
				ev.velocity    = vel;
				ev.last_of_run = (k == top);
				expected_notes.push_back(ev);
			end
		end
	endfunction

	// Advance the predictor by one accepted request word.
	function automatic void predict_notes(input req_word_t w);
		if (w.command == CMD_WRITE) begin
			step_masks[w.step_index] = w.step_mask;
		end else if (w.tick_position == '0) begin
			// position zero always plays the next step, even an empty one
			held_notes = step_masks[play_ptr];
			play_ptr   = (play_ptr == IDX_W'(STEP_COUNT_DEF - 1)) ? '0 : play_ptr + 1'b1;
			queue_run(held_notes, VEL_ON);
		end else if (w.tick_position == note_off_pos) begin
			// held mask survives note-offs, so a repeat tick repeats them
			queue_run(held_notes, VEL_OFF);
		end
	endfunction

	// Event checker: every accepted event is matched against the oldest expectation.
	always @(posedge clk) begin : check_events
		evt_word_t want;
		if (arst_n && evt_valid === 1'b1 && evt_stall === 1'b0) begin
			if (expected_notes.size() == 0) begin
				flag_error($sformatf("unexpected event note %0d vel %0d last %0b",
					evt_word.note_number, evt_word.velocity, evt_word.last_of_run));
			end else begin
				want = expected_notes.pop_front();
				if (evt_word.note_number !== want.note_number ||
						evt_word.velocity !== want.velocity ||
						evt_word.last_of_run !== want.last_of_run)
					flag_error($sformatf(
						"event mismatch: exp note %0d vel %0d last %0b, got note %0d vel %0d last %0b",
						want.note_number, want.velocity, want.last_of_run,
						evt_word.note_number, evt_word.velocity, evt_word.last_of_run));
			end
		end
	end

	// Receiver: random stalls, a quiet stretch, and long hold-offs on request.
	always @(negedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_left <= HOLD_CYCLES;
			evt_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			evt_stall <= 1'b1;
		end else if (quiet_stretch) begin
			evt_stall <= 1'b0;
		end else begin
			evt_stall <= ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Sender gap length: geometric, about a third of cycles idle.
	function automatic int idle_gap();
		int gap;
		gap = 0;
		if (!quiet_stretch)
			while ($urandom_range(0, 99) < IDLE_PCT) gap++;
		return gap;
	endfunction

	// Offer one word and wait for it to be taken. Enters and leaves at a falling
	// edge; valid stays high afterwards so back-to-back words need no gap.
	task automatic send_word(input req_word_t w);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (req_stall !== 1'b0);
		predict_notes(w);
		@(negedge clk);
	endtask

	// Drop valid, wait for every owed event, then let a trailing empty tick finish.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(negedge clk);
		while (expected_notes.size() != 0) @(negedge clk);
		repeat (DRAIN_PAD) @(negedge clk);
	endtask

	task automatic set_note_off_position(input logic [POS_W-1:0] pos);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= pos;
		@(negedge clk);
		cfg_we       <= 1'b0;
		note_off_pos  = pos;
	endtask

	// Word builders; unused fields carry random noise.
	function automatic req_word_t step_write(input logic [IDX_W-1:0] idx,
			input logic [MASK_W-1:0] mask);
		req_word_t w;
		w.command       = CMD_WRITE;
		w.tick_position = POS_W'($urandom);
		w.step_index    = idx;
		w.step_mask     = mask;
		return w;
	endfunction

	function automatic req_word_t clock_tick(input logic [POS_W-1:0] pos);
		req_word_t w;
		w.command       = CMD_TICK;
		w.tick_position = pos;
		w.step_index    = IDX_W'($urandom);
		w.step_mask     = MASK_W'($urandom);
		return w;
	endfunction

	function automatic logic [MASK_W-1:0] pick_mask();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		return MASK_W'($urandom);
	endfunction

	// Ticks on a freshly reset block: empty table, so nothing plays.
	task automatic test_reset_state();
		send_word(clock_tick('0));
		send_word(clock_tick(OFF_POS_RST));
		send_word(clock_tick(8'd255));
	endtask

	// Mask extremes, empty step, repeated note-off, non-matching positions.
	task automatic test_step_playback();
		send_word(step_write(3'd2, 12'hFFF));
		send_word(step_write(3'd3, 12'h001));
		send_word(step_write(3'd4, 12'h800));
		send_word(step_write(3'd6, 12'hAAA));
		send_word(clock_tick('0));           // step 1: still empty
		send_word(clock_tick('0));           // step 2: all twelve notes
		send_word(clock_tick(OFF_POS_RST));
		send_word(clock_tick(OFF_POS_RST));  // same note-offs again
		send_word(step_write(3'd3, 12'h555)); // overwrite before it plays
		send_word(clock_tick('0));           // step 3
		send_word(clock_tick(8'd23));        // near miss: nothing
		send_word(clock_tick('0));           // step 4: top note only
		send_word(clock_tick(OFF_POS_RST));
		send_word(clock_tick('0));           // step 5: empty, held becomes empty
		send_word(clock_tick(OFF_POS_RST));  // nothing held
	endtask

	// Note-off position at 1 and at 255; the old position stops matching.
	task automatic test_off_position();
		set_note_off_position(8'd1);
		send_word(clock_tick('0));           // step 6
		send_word(clock_tick(8'd1));
		send_word(clock_tick(OFF_POS_RST));
		set_note_off_position(8'd255);
		send_word(clock_tick(8'd255));
		send_word(clock_tick(8'd254));
		set_note_off_position(OFF_POS_RST);
	endtask

	// Output held off for a long stretch while full runs keep coming, so the
	// block backs up into its input.
	task automatic test_output_hold();
		wait_drained();
		for (int i = 0; i < STEP_COUNT_DEF; i++)
			send_word(step_write(IDX_W'(i), pick_mask() | 12'h801));
		hold_ask++;
		for (int i = 0; i < 10; i++)
			send_word(clock_tick($urandom_range(0, 1) ? '0 : note_off_pos));
	endtask

	// Mostly musical traffic: writes, step ticks, note-off ticks, some noise.
	task automatic test_random_traffic();
		int r;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 15) quiet_stretch = 1'b1;
			if (i == 40) quiet_stretch = 1'b0;
			if (i == 25) wait_drained();     // sender pauses until all events are in
			if (i == 50) set_note_off_position(POS_W'($urandom_range(1, 255)));
			r = $urandom_range(0, 99);
			if (r < 30)
				send_word(step_write(IDX_W'($urandom), pick_mask()));
			else if (r < 60)
				send_word(clock_tick('0));
			else if (r < 85)
				send_word(clock_tick(note_off_pos));
			else
				send_word(clock_tick(POS_W'($urandom)));
		end
	endtask

	initial begin
		for (int i = 0; i < STEP_COUNT_DEF; i++) step_masks[i] = '0;
		play_ptr     = '0;
		held_notes   = '0;
		note_off_pos = OFF_POS_RST;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_step_playback();
		test_off_position();
		test_output_hold();
		test_random_traffic();

		wait_drained();
		if (expected_notes.size() != 0)
			flag_error($sformatf("%0d events never arrived", expected_notes.size()));
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
